// ===== src/assert_macros.svh =====
// Assertion macros used by the controller RTL of the steady-state window detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sswd_pkg.sv =====
// Types and fixed constants shared by the steady-state window detector modules.
`timescale 1ns / 1ps
`default_nettype none

package sswd_pkg;

  localparam int CH_W         = 3;
  localparam int CEL_W        = 20;
  localparam int FAH_W        = 21;
  localparam int THR_W        = 16;
  localparam int SAMPLE_MAG_W = 20;   // bits of |fahrenheit| for any legal input
  localparam int SQ_W         = 2 * SAMPLE_MAG_W;

  localparam logic [THR_W-1:0] THR_RESET = 16'd64;

  // round(9c/5) = floor((9c + 2 + 5*2^20) / 5) - 2^20, numerator always positive
  localparam int NUM_W     = 24;
  localparam int NUM_EXT_W = 26;
  localparam logic signed [NUM_EXT_W-1:0] NUM_BIAS = 26'sd5242882;
  localparam logic signed [NUM_EXT_W-1:0] NUM_MUL  = 26'sd9;

  // divide by five as multiply by ceil(2^26/5), exact for numerators below 2^25
  localparam logic [NUM_W-1:0] DIV5_RECIP = 24'd13421773;
  localparam int DIV5_SHIFT = 26;
  localparam int QUOT_W     = 2 * NUM_W - DIV5_SHIFT;

  // remove the 2^20 bias and add 32 degrees (8192 in 1/256 units)
  localparam logic [QUOT_W:0] F_OFFSET = 23'd1040384;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SQNEW,
    S_SQOLD,
    S_UPD,
    S_SQSUM,
    S_CMP
  } state_t;

  typedef enum logic [1:0] {
    MUL_THR,
    MUL_NEW,
    MUL_OLD,
    MUL_SUM
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     conv;
    logic     ram_rd;
    logic     load_old;
    logic     ram_wr;
    logic     update;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic ch_ok;
  } status_t;

endpackage

`default_nettype wire

// ===== src/steady_state_window_detector_top.sv =====
// Top level of the steady-state window detector: controller plus datapath.
//
// Input channel (in_valid/in_ready): one request carries channel_index and
// celsius_sample. Output channel (out_valid/out_ready): one result per request,
// with channel_out, fahrenheit_value, window_full and steady.
// Configuration: cfg_we with cfg_data writes the deviation threshold; write it
// only while no request is in flight.
// Sequence: an accepted request for a configured channel steps through S_CONV,
// S_SQNEW, S_SQOLD, S_UPD, S_SQSUM and S_CMP, from which result and out_valid
// are registered; a channel beyond NUM_CHANNELS goes from S_CONV to S_CMP and
// leaves no state. Requests are taken one at a time, only in S_IDLE, paced by
// the single shared multiplier that forms threshold, new, old and sum squares
// in turn around the ring read-modify-write.
// The result sits in an output register; a stalled receiver holds it and the
// block accepts the next request meanwhile, waiting before its own result.
// Reset (rst, synchronous): threshold back to 64, all rings empty, sums and
// write positions zero; slots not yet written read as zero, so no clearing
// pass is needed and the block is ready for a request straight out of reset.
`timescale 1ns / 1ps
`default_nettype none

module steady_state_window_detector_top #(
  parameter int WINDOW       = 16,
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [sswd_pkg::CH_W-1:0]    channel_index,
  input  wire logic signed [sswd_pkg::CEL_W-1:0]   celsius_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [sswd_pkg::CH_W-1:0]    channel_out,
  output logic signed      [sswd_pkg::FAH_W-1:0]   fahrenheit_value,
  output logic                                     window_full,
  output logic                                     steady,
  input  wire logic                                cfg_we,
  input  wire logic        [sswd_pkg::THR_W-1:0]   cfg_data
);

  sswd_pkg::cmd_t    cmd;
  sswd_pkg::status_t status;

  sswd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sswd_datapath #(
    .WINDOW       (WINDOW),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .channel_index    (channel_index),
    .celsius_sample   (celsius_sample),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .channel_out      (channel_out),
    .fahrenheit_value (fahrenheit_value),
    .window_full      (window_full),
    .steady           (steady)
  );

endmodule

`default_nettype wire

// ===== src/sswd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sswd_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sswd_ctrl.sv =====
// Controller state machine of the steady-state window detector.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sswd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sswd_pkg::status_t status,
  output sswd_pkg::cmd_t         cmd
);

  sswd_pkg::state_t state;
  sswd_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sswd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sswd_pkg::S_IDLE:  if (in_valid) state_next = sswd_pkg::S_CONV;
      // skip ring work for a channel beyond the configured count
      sswd_pkg::S_CONV:  state_next = status.ch_ok ? sswd_pkg::S_SQNEW : sswd_pkg::S_CMP;
      sswd_pkg::S_SQNEW: state_next = sswd_pkg::S_SQOLD;
      sswd_pkg::S_SQOLD: state_next = sswd_pkg::S_UPD;
      sswd_pkg::S_UPD:   state_next = sswd_pkg::S_SQSUM;
      sswd_pkg::S_SQSUM: state_next = sswd_pkg::S_CMP;
      sswd_pkg::S_CMP:   if (out_free) state_next = sswd_pkg::S_IDLE;
      default:           state_next = sswd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      sswd_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      sswd_pkg::S_CONV: begin
        cmd.conv     = 1'b1;
        cmd.ram_rd   = status.ch_ok;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = sswd_pkg::MUL_THR;
      end
      sswd_pkg::S_SQNEW: begin
        cmd.load_old = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = sswd_pkg::MUL_NEW;
      end
      sswd_pkg::S_SQOLD: begin
        cmd.ram_wr   = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = sswd_pkg::MUL_OLD;
      end
      sswd_pkg::S_UPD: begin
        cmd.update = 1'b1;
      end
      sswd_pkg::S_SQSUM: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = sswd_pkg::MUL_SUM;
      end
      sswd_pkg::S_CMP: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == sswd_pkg::S_CONV, "accepted request did not start conversion")
  `ASSERT_NEXT(a_result_shown, clk, rst, state == sswd_pkg::S_CMP && out_free, out_valid, "finished result not presented")
  `ASSERT_IMPLY(a_update_in_range, clk, rst, cmd.update || cmd.ram_wr, status.ch_ok, "ring update for channel out of range")

endmodule

`default_nettype wire

// ===== src/sswd_datapath.sv =====
// Datapath: conversion, sample rings, running sums, shared multiplier and compare.
`timescale 1ns / 1ps
`default_nettype none

module sswd_datapath #(
  parameter int WINDOW       = 16,
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sswd_pkg::cmd_t                      cmd,
  output sswd_pkg::status_t                        status,
  input  wire logic        [sswd_pkg::CH_W-1:0]    channel_index,
  input  wire logic signed [sswd_pkg::CEL_W-1:0]   celsius_sample,
  input  wire logic                                cfg_we,
  input  wire logic        [sswd_pkg::THR_W-1:0]   cfg_data,
  output logic             [sswd_pkg::CH_W-1:0]    channel_out,
  output logic signed      [sswd_pkg::FAH_W-1:0]   fahrenheit_value,
  output logic                                     window_full,
  output logic                                     steady
);

  localparam int PW    = $clog2(WINDOW);
  localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH = NUM_CHANNELS * WINDOW;
  localparam int ADW   = $clog2(DEPTH);
  localparam int MW    = sswd_pkg::SAMPLE_MAG_W + PW;
  localparam int SW    = sswd_pkg::FAH_W + PW;
  localparam int QW    = sswd_pkg::SQ_W + PW;
  localparam int LW    = QW + PW;
  localparam int FW    = sswd_pkg::FAH_W;

  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
  localparam logic [LW-1:0] N_L      = LW'(WINDOW);
  localparam logic [LW-1:0] N_SQ_L   = LW'(WINDOW * WINDOW);

  logic        [sswd_pkg::CH_W-1:0]   ch_q;
  logic        [sswd_pkg::NUM_W-1:0]  num_q;
  logic signed [FW-1:0]               f_q;
  logic signed [FW-1:0]               old_q;
  logic        [sswd_pkg::THR_W-1:0]  thr_q;
  logic        [2*sswd_pkg::THR_W-1:0] tsq_q;
  logic        [sswd_pkg::SQ_W-1:0]   sq_new_q;
  logic        [sswd_pkg::SQ_W-1:0]   sq_old_q;
  logic signed [SW-1:0]               sum_q;
  logic        [QW-1:0]               sumsq_q;
  logic        [2*MW-1:0]             ssq_q;
  logic                               full_q;

  logic        [PW-1:0] pos_mem   [NUM_CHANNELS];
  logic                 filled    [NUM_CHANNELS];
  logic signed [SW-1:0] sum_mem   [NUM_CHANNELS];
  logic        [QW-1:0] sumsq_mem [NUM_CHANNELS];

  logic signed [sswd_pkg::NUM_EXT_W-1:0] c_ext;
  logic signed [sswd_pkg::NUM_EXT_W-1:0] num_ext;
  logic        [2*sswd_pkg::NUM_W-1:0]   conv_p;
  logic        [sswd_pkg::QUOT_W-1:0]    quot;
  logic signed [FW-1:0]                  f_calc;

  logic [CHW-1:0]  ch_idx;
  logic            ch_ok;
  logic [PW-1:0]   cur_pos;
  logic            cur_filled;
  logic [ADW-1:0]  addr;
  logic [FW-1:0]   rdata;

  logic [FW-1:0]   f_mag;
  logic [FW-1:0]   old_mag;
  logic [SW-1:0]   sum_mag;
  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] mul_p;

  logic signed [SW-1:0] sum_next;
  logic        [QW-1:0] sumsq_next;
  logic        [LW-1:0] lhs;
  logic        [LW-1:0] rhs;

  // conversion numerator from the raw input
  assign c_ext   = sswd_pkg::NUM_EXT_W'(celsius_sample);
  assign num_ext = c_ext * sswd_pkg::NUM_MUL + sswd_pkg::NUM_BIAS;

  assign conv_p = num_q * sswd_pkg::DIV5_RECIP;
  assign quot   = conv_p[2*sswd_pkg::NUM_W-1:sswd_pkg::DIV5_SHIFT];
  assign f_calc = FW'({1'b0, quot} - sswd_pkg::F_OFFSET);

  assign ch_idx       = CHW'({{CHW{1'b0}}, ch_q});
  assign ch_ok        = int'(ch_q) < NUM_CHANNELS;
  assign status.ch_ok = ch_ok;
  assign cur_pos      = pos_mem[ch_idx];
  assign cur_filled   = filled[ch_idx];
  assign addr         = ADW'(int'(ch_idx) * WINDOW + int'(cur_pos));

  sswd_ram #(
    .WIDTH (FW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (addr),
    .wdata (f_q),
    .re    (cmd.ram_rd),
    .raddr (addr),
    .rdata (rdata)
  );

  assign f_mag   = f_q[FW-1] ? FW'(-f_q) : FW'(f_q);
  assign old_mag = old_q[FW-1] ? FW'(-old_q) : FW'(old_q);
  assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

  // shared unsigned multiplier on magnitudes
  always_comb begin
    unique case (cmd.mul_sel)
      sswd_pkg::MUL_THR: mul_a = MW'(thr_q);
      sswd_pkg::MUL_NEW: mul_a = MW'(f_mag);
      sswd_pkg::MUL_OLD: mul_a = MW'(old_mag);
      sswd_pkg::MUL_SUM: mul_a = MW'(sum_mag);
      default:           mul_a = '0;
    endcase
    mul_b = mul_a;
  end

  assign mul_p = mul_a * mul_b;

  assign sum_next   = sum_mem[ch_idx] + SW'(f_q) - SW'(old_q);
  assign sumsq_next = sumsq_mem[ch_idx] + QW'(sq_new_q) - QW'(sq_old_q);

  assign lhs = LW'(sumsq_q) * N_L - LW'(ssq_q);
  assign rhs = LW'(tsq_q) * N_SQ_L;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_q  <= channel_index;
      num_q <= num_ext[sswd_pkg::NUM_W-1:0];
    end
    if (cmd.conv) begin
      f_q <= f_calc;
    end
    // a slot not yet written since reset reads as zero
    if (cmd.load_old) begin
      old_q <= cur_filled ? $signed(rdata) : '0;
    end
    if (cmd.mul_load) begin
      unique case (cmd.mul_sel)
        sswd_pkg::MUL_THR: tsq_q    <= mul_p[2*sswd_pkg::THR_W-1:0];
        sswd_pkg::MUL_NEW: sq_new_q <= mul_p[sswd_pkg::SQ_W-1:0];
        sswd_pkg::MUL_OLD: sq_old_q <= mul_p[sswd_pkg::SQ_W-1:0];
        sswd_pkg::MUL_SUM: ssq_q    <= mul_p;
        default: begin
        end
      endcase
    end
    if (cmd.update) begin
      sum_q   <= sum_next;
      sumsq_q <= sumsq_next;
      full_q  <= cur_filled || (cur_pos == POS_LAST);
    end
    if (cmd.load_out) begin
      channel_out      <= ch_q;
      fahrenheit_value <= f_q;
      window_full      <= ch_ok && full_q;
      steady           <= ch_ok && full_q && (lhs < rhs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_q <= sswd_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_q <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_mem[i]   <= '0;
        filled[i]    <= 1'b0;
        sum_mem[i]   <= '0;
        sumsq_mem[i] <= '0;
      end
    end else if (cmd.update) begin
      sum_mem[ch_idx]   <= sum_next;
      sumsq_mem[ch_idx] <= sumsq_next;
      // advance the write slot, wrap and mark the ring full
      if (cur_pos == POS_LAST) begin
        pos_mem[ch_idx] <= '0;
        filled[ch_idx]  <= 1'b1;
      end else begin
        pos_mem[ch_idx] <= cur_pos + PW'(1);
      end
    end
  end

endmodule

`default_nettype wire
